// ===== rtl/acbe_pkg.sv =====
// ----------------------------------------------------------------------------
// acbe_pkg: shared types and constants for the block cipher engine
// Substitution tables, round constants, field multiply and register codes.
// ----------------------------------------------------------------------------
`default_nettype none

package acbe_pkg;

   typedef enum logic [1:0] {
      CMD_RAW_ENC = 2'd0,
      CMD_RAW_DEC = 2'd1,
      CMD_CBC_ENC = 2'd2,
      CMD_CBC_DEC = 2'd3
   } cmd_type;

   localparam logic [2:0] REG_KEY0  = 3'd0;
   localparam logic [2:0] REG_KEY1  = 3'd1;
   localparam logic [2:0] REG_KEY2  = 3'd2;
   localparam logic [2:0] REG_NK    = 3'd3;
   localparam logic [2:0] REG_TWEAK = 3'd4;
   localparam logic [2:0] REG_IVH   = 3'd5;
   localparam logic [2:0] REG_IVL   = 3'd6;

   localparam logic [31:0] TWEAK_4 = 32'h7300_0000;
   localparam logic [31:0] TWEAK_6 = 32'h0900_0000;
   localparam logic [31:0] TWEAK_8 = 32'hE400_0000;

   typedef logic [7:0] sbox_type [256];

   localparam sbox_type FWD_SUB = '{
   8'h63,8'h7C,8'h77,8'h7B,8'hF2,8'h6B,8'h6F,8'hC5,8'h30,8'h01,8'h67,8'h2B,8'hFE,8'hD7,8'hAB,8'h76,
   8'hCA,8'h82,8'hC9,8'h7D,8'hFA,8'h59,8'h47,8'hF0,8'hAD,8'hD4,8'hA2,8'hAF,8'h9C,8'hA4,8'h72,8'hC0,
   8'hB7,8'hFD,8'h93,8'h26,8'h36,8'h3F,8'hF7,8'hCC,8'h34,8'hA5,8'hE5,8'hF1,8'h71,8'hD8,8'h31,8'h15,
   8'h04,8'hC7,8'h23,8'hC3,8'h18,8'h96,8'h05,8'h9A,8'h07,8'h12,8'h80,8'hE2,8'hEB,8'h27,8'hB2,8'h75,
   8'h09,8'h83,8'h2C,8'h1A,8'h1B,8'h6E,8'h5A,8'hA0,8'h52,8'h3B,8'hD6,8'hB3,8'h29,8'hE3,8'h2F,8'h84,
   8'h53,8'hD1,8'h00,8'hED,8'h20,8'hFC,8'hB1,8'h5B,8'h6A,8'hCB,8'hBE,8'h39,8'h4A,8'h4C,8'h58,8'hCF,
   8'hD0,8'hEF,8'hAA,8'hFB,8'h43,8'h4D,8'h33,8'h85,8'h45,8'hF9,8'h02,8'h7F,8'h50,8'h3C,8'h9F,8'hA8,
   8'h51,8'hA3,8'h40,8'h8F,8'h92,8'h9D,8'h38,8'hF5,8'hBC,8'hB6,8'hDA,8'h21,8'h10,8'hFF,8'hF3,8'hD2,
   8'hCD,8'h0C,8'h13,8'hEC,8'h5F,8'h97,8'h44,8'h17,8'hC4,8'hA7,8'h7E,8'h3D,8'h64,8'h5D,8'h19,8'h73,
   8'h60,8'h81,8'h4F,8'hDC,8'h22,8'h2A,8'h90,8'h88,8'h46,8'hEE,8'hB8,8'h14,8'hDE,8'h5E,8'h0B,8'hDB,
   8'hE0,8'h32,8'h3A,8'h0A,8'h49,8'h06,8'h24,8'h5C,8'hC2,8'hD3,8'hAC,8'h62,8'h91,8'h95,8'hE4,8'h79,
   8'hE7,8'hC8,8'h37,8'h6D,8'h8D,8'hD5,8'h4E,8'hA9,8'h6C,8'h56,8'hF4,8'hEA,8'h65,8'h7A,8'hAE,8'h08,
   8'hBA,8'h78,8'h25,8'h2E,8'h1C,8'hA6,8'hB4,8'hC6,8'hE8,8'hDD,8'h74,8'h1F,8'h4B,8'hBD,8'h8B,8'h8A,
   8'h70,8'h3E,8'hB5,8'h66,8'h48,8'h03,8'hF6,8'h0E,8'h61,8'h35,8'h57,8'hB9,8'h86,8'hC1,8'h1D,8'h9E,
   8'hE1,8'hF8,8'h98,8'h11,8'h69,8'hD9,8'h8E,8'h94,8'h9B,8'h1E,8'h87,8'hE9,8'hCE,8'h55,8'h28,8'hDF,
   8'h8C,8'hA1,8'h89,8'h0D,8'hBF,8'hE6,8'h42,8'h68,8'h41,8'h99,8'h2D,8'h0F,8'hB0,8'h54,8'hBB,8'h16};

   localparam sbox_type INV_SUB = '{
   8'h52,8'h09,8'h6A,8'hD5,8'h30,8'h36,8'hA5,8'h38,8'hBF,8'h40,8'hA3,8'h9E,8'h81,8'hF3,8'hD7,8'hFB,
   8'h7C,8'hE3,8'h39,8'h82,8'h9B,8'h2F,8'hFF,8'h87,8'h34,8'h8E,8'h43,8'h44,8'hC4,8'hDE,8'hE9,8'hCB,
   8'h54,8'h7B,8'h94,8'h32,8'hA6,8'hC2,8'h23,8'h3D,8'hEE,8'h4C,8'h95,8'h0B,8'h42,8'hFA,8'hC3,8'h4E,
   8'h08,8'h2E,8'hA1,8'h66,8'h28,8'hD9,8'h24,8'hB2,8'h76,8'h5B,8'hA2,8'h49,8'h6D,8'h8B,8'hD1,8'h25,
   8'h72,8'hF8,8'hF6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hD4,8'hA4,8'h5C,8'hCC,8'h5D,8'h65,8'hB6,8'h92,
   8'h6C,8'h70,8'h48,8'h50,8'hFD,8'hED,8'hB9,8'hDA,8'h5E,8'h15,8'h46,8'h57,8'hA7,8'h8D,8'h9D,8'h84,
   8'h90,8'hD8,8'hAB,8'h00,8'h8C,8'hBC,8'hD3,8'h0A,8'hF7,8'hE4,8'h58,8'h05,8'hB8,8'hB3,8'h45,8'h06,
   8'hD0,8'h2C,8'h1E,8'h8F,8'hCA,8'h3F,8'h0F,8'h02,8'hC1,8'hAF,8'hBD,8'h03,8'h01,8'h13,8'h8A,8'h6B,
   8'h3A,8'h91,8'h11,8'h41,8'h4F,8'h67,8'hDC,8'hEA,8'h97,8'hF2,8'hCF,8'hCE,8'hF0,8'hB4,8'hE6,8'h73,
   8'h96,8'hAC,8'h74,8'h22,8'hE7,8'hAD,8'h35,8'h85,8'hE2,8'hF9,8'h37,8'hE8,8'h1C,8'h75,8'hDF,8'h6E,
   8'h47,8'hF1,8'h1A,8'h71,8'h1D,8'h29,8'hC5,8'h89,8'h6F,8'hB7,8'h62,8'h0E,8'hAA,8'h18,8'hBE,8'h1B,
   8'hFC,8'h56,8'h3E,8'h4B,8'hC6,8'hD2,8'h79,8'h20,8'h9A,8'hDB,8'hC0,8'hFE,8'h78,8'hCD,8'h5A,8'hF4,
   8'h1F,8'hDD,8'hA8,8'h33,8'h88,8'h07,8'hC7,8'h31,8'hB1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hEC,8'h5F,
   8'h60,8'h51,8'h7F,8'hA9,8'h19,8'hB5,8'h4A,8'h0D,8'h2D,8'hE5,8'h7A,8'h9F,8'h93,8'hC9,8'h9C,8'hEF,
   8'hA0,8'hE0,8'h3B,8'h4D,8'hAE,8'h2A,8'hF5,8'hB0,8'hC8,8'hEB,8'hBB,8'h3C,8'h83,8'h53,8'h99,8'h61,
   8'h17,8'h2B,8'h04,8'h7E,8'hBA,8'h77,8'hD6,8'h26,8'hE1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0C,8'h7D};

   typedef logic [31:0] rcon_type [11];
   localparam rcon_type RCON = '{
      32'h0000_0000, 32'h0100_0000, 32'h0200_0000, 32'h0400_0000, 32'h0800_0000,
      32'h1000_0000, 32'h2000_0000, 32'h4000_0000, 32'h8000_0000, 32'h1B00_0000,
      32'h3600_0000};

   function automatic logic [31:0] sub_word(input logic [31:0] w);
      return {FWD_SUB[w[31:24]], FWD_SUB[w[23:16]], FWD_SUB[w[15:8]], FWD_SUB[w[7:0]]};
   endfunction

   function automatic logic [31:0] gf_mul2(input logic [31:0] w);
      logic [31:0] hi;
      hi = (w & 32'h8080_8080) >> 7;
      return ((w & 32'h7f7f_7f7f) << 1) ^ (hi * 32'h1b);
   endfunction

   function automatic logic [31:0] rotl8(input logic [31:0] w);
      return {w[23:0], w[31:24]};
   endfunction

endpackage : acbe_pkg

`default_nettype wire

// ===== rtl/acbe_key_sched.sv =====
// ----------------------------------------------------------------------------
// acbe_key_sched: round key expansion sequencer
// Derives one key word per cycle into the round key memory, then applies
// the optional tweak in three further writes. Also serves round key
// reads for the datapath, one 128-bit row per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module acbe_key_sched #(
   parameter int ROUND_KEY_WORDS = 52
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         start,
   input  wire logic [191:0] key,
   input  wire logic [2:0]   nk_cfg,
   input  wire logic         tweak,
   input  wire logic [3:0]   rd_round,
   output logic [127:0]      rd_key,
   output logic [3:0]        rounds,
   output logic              busy
);
   import acbe_pkg::*;

   localparam int ROWS  = ROUND_KEY_WORDS / 4;
   localparam int MAXK  = (ROWS >= 11) ? (ROWS - 7) : 4;
   localparam int RW    = $clog2(ROWS);

   typedef enum logic [1:0] {KS_IDLE, KS_EXPAND, KS_TWEAK} ks_state_type;

   // one memory per column, so a whole round key reads in a single access
   logic [31:0] mem0 [ROWS];
   logic [31:0] mem1 [ROWS];
   logic [31:0] mem2 [ROWS];
   logic [31:0] mem3 [ROWS];

   ks_state_type state_ff;
   logic [5:0]   idx_ff, idx_in;
   logic [2:0]   nk_ff;
   logic [2:0]   phase_ff;    // i mod nk
   logic [3:0]   quot_ff;     // i div nk
   logic [1:0]   tw_ff;
   logic         twk_ff;
   logic [3:0]   rounds_ff;
   logic [31:0]  hist_ff [6]; // last nk words, hist_ff[0] newest
   logic [31:0]  word, temp;
   logic [5:0]   total;
   logic [2:0]   nk_sel;
   logic         wr_en;
   logic [5:0]   wr_idx;
   logic [31:0]  wr_data;
   logic [31:0]  tw_mask;
   logic [31:0]  old_w;
   logic [31:0]  rd0_ff, rd1_ff, rd2_ff, rd3_ff;

   always_comb begin
      if (nk_cfg < 3'd4) nk_sel = 3'd4;
      else if (nk_cfg > 3'd6) nk_sel = 3'd6;
      else nk_sel = nk_cfg;
      if (nk_sel > 3'(MAXK)) nk_sel = 3'(MAXK);
   end

   assign total = 6'((rounds_ff + 4'd1) * 3'd4);

   always_comb begin
      temp = hist_ff[0];
      if (phase_ff == 3'd0) temp = sub_word(rotl8(hist_ff[0])) ^ RCON[quot_ff];
      word = hist_ff[nk_ff - 3'd1] ^ temp;
   end

   always_comb begin
      case (tw_ff)
         2'd0:    tw_mask = TWEAK_4;
         2'd1:    tw_mask = TWEAK_6;
         default: tw_mask = TWEAK_8;
      endcase
   end

   // column 0 of rows 4, 6, 8 are rewritten in the tweak pass
   assign old_w = mem0[RW'(5'd4 + {tw_ff, 1'b0} + 5'd0)];

   always_comb begin
      wr_en   = 1'b0;
      wr_idx  = idx_ff;
      wr_data = word;
      idx_in  = idx_ff;
      if (state_ff == KS_EXPAND) begin
         wr_en = 1'b1;
         if (idx_ff < 6'(nk_ff)) wr_data = hist_ff[nk_ff - 3'd1];
         idx_in = idx_ff + 6'd1;
      end else if (state_ff == KS_TWEAK) begin
         wr_en   = 1'b1;
         wr_idx  = 6'(16 + 8 * tw_ff);
         wr_data = old_w ^ tw_mask;
      end
      if (start) idx_in = '0;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         case (wr_idx[1:0])
            2'd0:    mem0[wr_idx[RW+1:2]] <= wr_data;
            2'd1:    mem1[wr_idx[RW+1:2]] <= wr_data;
            2'd2:    mem2[wr_idx[RW+1:2]] <= wr_data;
            default: mem3[wr_idx[RW+1:2]] <= wr_data;
         endcase
      end
      rd0_ff <= mem0[rd_round[RW-1:0]];
      rd1_ff <= mem1[rd_round[RW-1:0]];
      rd2_ff <= mem2[rd_round[RW-1:0]];
      rd3_ff <= mem3[rd_round[RW-1:0]];
   end

   assign rd_key = {rd0_ff, rd1_ff, rd2_ff, rd3_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= KS_IDLE;
         rounds_ff <= 4'd10;
         idx_ff    <= '0;
         tw_ff     <= '0;
      end else begin
         idx_ff <= idx_in;
         // a write to a mapped register restarts the expansion from any state
         if (start) begin
            state_ff  <= KS_EXPAND;
            nk_ff     <= nk_sel;
            rounds_ff <= 4'(nk_sel + 3'd6);
            twk_ff    <= tweak;
            phase_ff  <= '0;
            quot_ff   <= 4'd1;
            // key words loaded so that hist_ff[nk-1] is word 0
            for (int k = 0; k < 6; k++) begin
               hist_ff[k] <= key[32*(k+6-int'(nk_sel)) +: 32];
            end
         end else begin
            case (state_ff)
               KS_IDLE: begin
                  state_ff <= KS_IDLE;
               end
               KS_EXPAND: begin
                  for (int k = 5; k > 0; k--) hist_ff[k] <= hist_ff[k-1];
                  hist_ff[0] <= wr_data;
                  if (idx_ff >= 6'(nk_ff)) begin
                     if (phase_ff == nk_ff - 3'd1) begin
                        phase_ff <= '0;
                        quot_ff  <= quot_ff + 4'd1;
                     end else begin
                        phase_ff <= phase_ff + 3'd1;
                     end
                  end
                  if (idx_ff == total - 6'd1) begin
                     tw_ff    <= '0;
                     state_ff <= twk_ff ? KS_TWEAK : KS_IDLE;
                  end
               end
               KS_TWEAK: begin
                  tw_ff <= tw_ff + 2'd1;
                  if (tw_ff == 2'd2) state_ff <= KS_IDLE;
               end
               default: state_ff <= KS_IDLE;
            endcase
         end
      end
   end

   assign rounds = rounds_ff;
   assign busy   = (state_ff != KS_IDLE);

endmodule : acbe_key_sched

`default_nettype wire

// ===== rtl/acbe_round.sv =====
// ----------------------------------------------------------------------------
// acbe_round: shared cipher round unit
// One forward or inverse round of the state with the given round key, or the key addition alone.
// ----------------------------------------------------------------------------
`default_nettype none

module acbe_round (
   input  wire logic [127:0] state,
   input  wire logic [127:0] rkey,
   input  wire logic         inverse,
   input  wire logic         do_mix,
   input  wire logic         key_only,
   output logic [127:0]      result
);
   import acbe_pkg::*;

   logic [31:0] s [4];
   logic [31:0] n [4];
   logic [31:0] m [4];
   logic [31:0] k [4];
   logic [31:0] w, r1, m2, m4, m8, e, b, d, n9, x;
   logic [7:0]  by;
   int          src;

   always_comb begin
      for (int c = 0; c < 4; c++) begin
         s[c] = state[127-32*c -: 32];
         k[c] = rkey[127-32*c -: 32];
      end
      for (int c = 0; c < 4; c++) begin
         for (int j = 0; j < 4; j++) begin
            src = inverse ? ((c + 4 - j) & 3) : ((c + j) & 3);
            by  = s[src][31-8*j -: 8];
            n[c][31-8*j -: 8] = inverse ? INV_SUB[by] : FWD_SUB[by];
         end
      end
      // encrypt: sub, shift, mix, key; decrypt: sub, shift, key, mix
      for (int c = 0; c < 4; c++) begin
         if (inverse) w = n[c] ^ k[c];
         else w = n[c];
         r1 = rotl8(w);
         m2 = gf_mul2(w);
         m4 = gf_mul2(m2);
         m8 = gf_mul2(m4);
         e  = m8 ^ m4 ^ m2;
         b  = m8 ^ m2 ^ w;
         d  = m8 ^ m4 ^ w;
         n9 = m8 ^ w;
         if (!do_mix) x = w;
         else if (inverse)
            x = e ^ rotl8(b) ^ {d[15:0], d[31:16]} ^ {n9[7:0], n9[31:8]};
         else
            x = m2 ^ gf_mul2(r1) ^ r1 ^ {w[15:0], w[31:16]} ^ {w[7:0], w[31:8]};
         if (key_only) m[c] = s[c] ^ k[c];
         else if (inverse) m[c] = x;
         else m[c] = x ^ k[c];
      end
      result = {m[0], m[1], m[2], m[3]};
   end

endmodule : acbe_round

`default_nettype wire

// ===== rtl/aes_cbc_block_engine.sv =====
// ----------------------------------------------------------------------------
// aes_cbc_block_engine: iterative block cipher engine with CBC chaining
// Raw and CBC encrypt/decrypt of 128-bit blocks with 4, 5 or 6 word keys.
// ----------------------------------------------------------------------------
// A request is taken only while the engine is idle; after a key fetch state it
// runs the initial key addition and one round per cycle through a single shared
// round unit, each round fetching its key row from the round key memory the
// cycle before. Keys of 4, 5 or 6 words give 10, 11 or 12 rounds. The result
// sits in an output register and the next request is taken once it has been
// delivered. Any write to a mapped register starts key expansion: one key word
// per cycle, then three tweak writes when the tweak is on; requests wait
// meanwhile. The chaining value survives register writes. Registers sit at
// byte address 8*index and read back as written, the key length and tweak
// registers in their low bits only.
// ----------------------------------------------------------------------------
`default_nettype none

module aes_cbc_block_engine #(
   parameter int ROUND_KEY_WORDS = 52
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_command,
   input  wire logic        req_chain_start,
   input  wire logic [63:0] req_block_high,
   input  wire logic [63:0] req_block_low,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [63:0]      rsp_result_high,
   output logic [63:0]      rsp_result_low,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [5:0]  csr_paddr,
   input  wire logic [63:0] csr_pwdata,
   output logic [63:0]      csr_prdata,
   output logic             csr_pready
);
   import acbe_pkg::*;

   typedef enum logic [1:0] {ST_IDLE, ST_FETCH, ST_RUN, ST_DONE} state_type;

   logic [63:0]  key0_ff, key1_ff, key2_ff, ivh_ff, ivl_ff;
   logic [2:0]   nk_ff;
   logic         tweak_ff;
   logic [127:0] chain_ff;
   logic         kick_ff;
   logic [2:0]   widx;
   logic         wr;

   state_type    state_ff;
   cmd_type      cmd_ff;
   logic [127:0] st_ff, st_in, pre_ff, cin_ff;
   logic [3:0]   rnd_ff;     // round about to be applied (0 is the initial key addition)
   logic [3:0]   rd_round;
   logic [127:0] rkey, round_out;
   logic [3:0]   rounds;
   logic         ks_busy, inverse, first, last;
   logic [127:0] result_ff;
   logic [127:0] blk, prev;

   assign csr_pready = 1'b1;
   assign widx       = csr_paddr[5:3];
   assign wr         = csr_psel & csr_penable & csr_pwrite;

   always_comb begin
      case (widx)
         REG_KEY0:  csr_prdata = key0_ff;
         REG_KEY1:  csr_prdata = key1_ff;
         REG_KEY2:  csr_prdata = key2_ff;
         REG_NK:    csr_prdata = {61'd0, nk_ff};
         REG_TWEAK: csr_prdata = {63'd0, tweak_ff};
         REG_IVH:   csr_prdata = ivh_ff;
         REG_IVL:   csr_prdata = ivl_ff;
         default:   csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key0_ff <= '0; key1_ff <= '0; key2_ff <= '0;
         ivh_ff  <= '0; ivl_ff  <= '0;
         nk_ff   <= 3'd4; tweak_ff <= 1'b0;
         kick_ff <= 1'b0;
      end else begin
         kick_ff <= wr && (widx != 3'd7);
         if (wr) begin
            case (widx)
               REG_KEY0:  key0_ff  <= csr_pwdata;
               REG_KEY1:  key1_ff  <= csr_pwdata;
               REG_KEY2:  key2_ff  <= csr_pwdata;
               REG_NK:    nk_ff    <= csr_pwdata[2:0];
               REG_TWEAK: tweak_ff <= csr_pwdata[0];
               REG_IVH:   ivh_ff   <= csr_pwdata;
               REG_IVL:   ivl_ff   <= csr_pwdata;
               default:   ;
            endcase
         end
      end
   end

   acbe_key_sched #(.ROUND_KEY_WORDS(ROUND_KEY_WORDS)) u_key (
      .clock    (clock),
      .reset    (reset),
      .start    (kick_ff),
      .key      ({key0_ff, key1_ff, key2_ff}),
      .nk_cfg   (nk_ff),
      .tweak    (tweak_ff),
      .rd_round (rd_round),
      .rd_key   (rkey),
      .rounds   (rounds),
      .busy     (ks_busy)
   );

   assign inverse = (cmd_ff == CMD_RAW_DEC) || (cmd_ff == CMD_CBC_DEC);
   assign first   = (state_ff == ST_RUN) && (rnd_ff == 4'd0);
   assign last    = (rnd_ff == rounds);

   // key row needed next cycle
   always_comb begin
      if (state_ff == ST_FETCH) rd_round = inverse ? rounds : 4'd0;
      else if (inverse) rd_round = rounds - rnd_ff - 4'd1;
      else rd_round = rnd_ff + 4'd1;
   end

   acbe_round u_round (
      .state    (st_ff),
      .rkey     (rkey),
      .inverse  (inverse),
      .do_mix   (!last),
      .key_only (first),
      .result   (round_out)
   );

   assign prev = req_chain_start ? {ivh_ff, ivl_ff} : chain_ff;
   assign blk  = {req_block_high, req_block_low};
   assign st_in = (req_command == CMD_CBC_ENC) ? (blk ^ prev) : blk;

   assign req_ready = (state_ff == ST_IDLE) && !ks_busy && !kick_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         chain_ff <= '0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (req_valid && req_ready) begin
                  cmd_ff   <= cmd_type'(req_command);
                  st_ff    <= st_in;
                  pre_ff   <= prev;
                  cin_ff   <= blk;
                  state_ff <= ST_FETCH;
               end
            end
            ST_FETCH: begin
               rnd_ff   <= '0;
               state_ff <= ST_RUN;
            end
            ST_RUN: begin
               st_ff  <= round_out;
               rnd_ff <= rnd_ff + 4'd1;
               if (last) begin
                  state_ff <= ST_DONE;
                  if (cmd_ff == CMD_CBC_DEC) begin
                     result_ff <= round_out ^ pre_ff;
                     chain_ff  <= cin_ff;
                  end else begin
                     result_ff <= round_out;
                     if (cmd_ff == CMD_CBC_ENC) chain_ff <= round_out;
                  end
               end
            end
            ST_DONE: begin
               if (rsp_ready) state_ff <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid       = (state_ff == ST_DONE);
   assign rsp_result_high = result_ff[127:64];
   assign rsp_result_low  = result_ff[63:0];

endmodule : aes_cbc_block_engine

`default_nettype wire

// ===== rtl/acbe_checker.sv =====
// ----------------------------------------------------------------------------
// acbe_checker: port-level checks for the block cipher engine
// Watches handshakes on the request and result channels and that the register port is always ready.
// ----------------------------------------------------------------------------
`default_nettype none

module acbe_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [63:0] rsp_result_high,
   input wire logic        csr_pready
);

   // no request while a result waits
   a_no_req_with_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready) else $error("request taken during result");

   // an accepted request does not give a result next cycle
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !rsp_valid) else $error("result too early");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid && $stable(rsp_result_high))
      else $error("result dropped");

   a_pready: assert property (@(posedge clock) csr_pready)
      else $error("pready low");

endmodule : acbe_checker

bind aes_cbc_block_engine acbe_checker u_chk (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
   .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
   .rsp_result_high(rsp_result_high), .csr_pready(csr_pready)
);

`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the CBC block cipher engine
// Drives raw and CBC requests under random back-pressure, predicts every
// result from a behavioural cipher model and compares each delivered block.
// ----------------------------------------------------------------------------

module tb_top;
   import acbe_pkg::*;

   // request as queued for the driver
   typedef struct {
      cmd_type     cmd;
      logic        chain_start;
      logic [63:0] blk_high;
      logic [63:0] blk_low;
   } blk_req_t;

   typedef struct {
      logic [63:0] high;
      logic [63:0] low;
   } blk_out_t;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_command = CMD_RAW_ENC;
   logic        req_chain_start = 1'b0;
   logic [63:0] req_block_high = '0;
   logic [63:0] req_block_low = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [63:0] rsp_result_high;
   logic [63:0] rsp_result_low;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [5:0]  csr_paddr = '0;
   logic [63:0] csr_pwdata = '0;
   logic [63:0] csr_prdata;
   logic        csr_pready;

   aes_cbc_block_engine u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_command(req_command),
      .req_chain_start(req_chain_start), .req_block_high(req_block_high),
      .req_block_low(req_block_low),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_result_high(rsp_result_high), .rsp_result_low(rsp_result_low),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // Cipher model: register copy, round key schedule and chaining value
   // ------------------------------------------------------------------------
   logic [63:0] key_word [3];
   logic [2:0]  key_len_cfg = 3'd4;
   logic        tweak_cfg = 1'b0;
   logic [63:0] iv_hi_cfg = '0;
   logic [63:0] iv_lo_cfg = '0;
   logic [31:0] sched [52];
   int          n_rounds = 10;
   logic [63:0] chain_hi = '0;
   logic [63:0] chain_lo = '0;

   function automatic logic [31:0] rol32(input logic [31:0] w, input int n);
      return (w << n) | (w >> (32 - n));
   endfunction

   function automatic logic [31:0] xtime4(input logic [31:0] w);
      logic [31:0] hi;
      hi = (w & 32'h8080_8080) >> 7;
      return ((w & 32'h7f7f_7f7f) << 1) ^ (hi * 32'h1b);
   endfunction

   function automatic logic [31:0] sbox_word(input logic [31:0] w);
      return {FWD_SUB[w[31:24]], FWD_SUB[w[23:16]], FWD_SUB[w[15:8]], FWD_SUB[w[7:0]]};
   endfunction

   // rebuild the round keys from the current register copy
   function automatic void build_schedule();
      int          nk;
      int          total;
      logic [31:0] kw [6];
      logic [31:0] t;
      nk = key_len_cfg;
      if (nk < 4) nk = 4;
      if (nk > 6) nk = 6;
      n_rounds = nk + 6;
      total = (n_rounds + 1) * 4;
      for (int k = 0; k < 3; k++) begin
         kw[2*k]   = key_word[k][63:32];
         kw[2*k+1] = key_word[k][31:0];
      end
      for (int i = 0; i < nk; i++) sched[i] = kw[i];
      for (int i = nk; i < total; i++) begin
         t = sched[i-1];
         if (i % nk == 0) t = sbox_word(rol32(t, 8)) ^ RCON[(i / nk) % 11];
         sched[i] = sched[i-nk] ^ t;
      end
      if (tweak_cfg) begin
         sched[16] ^= TWEAK_4;
         sched[24] ^= TWEAK_6;
         sched[32] ^= TWEAK_8;
      end
   endfunction

   function automatic void add_round_key(ref logic [31:0] s [4], input int base);
      for (int c = 0; c < 4; c++) s[c] ^= sched[(base + c) % 52];
   endfunction

   // byte substitution combined with the row shift
   function automatic void sub_rows(ref logic [31:0] s [4], input bit inv);
      logic [31:0] n [4];
      int          sh;
      int          src;
      logic [7:0]  b;
      for (int c = 0; c < 4; c++) begin
         n[c] = '0;
         for (int j = 0; j < 4; j++) begin
            sh  = 24 - 8 * j;
            src = inv ? ((c + 4 - j) & 3) : ((c + j) & 3);
            b   = s[src] >> sh;
            n[c] |= {24'h0, (inv ? INV_SUB[b] : FWD_SUB[b])} << sh;
         end
      end
      s = n;
   endfunction

   function automatic void mix_cols(ref logic [31:0] s [4], input bit inv);
      logic [31:0] w, r1, m2, m4, m8;
      for (int c = 0; c < 4; c++) begin
         w = s[c];
         if (!inv) begin
            r1 = rol32(w, 8);
            s[c] = xtime4(w) ^ xtime4(r1) ^ r1 ^ rol32(w, 16) ^ rol32(w, 24);
         end else begin
            m2 = xtime4(w);
            m4 = xtime4(m2);
            m8 = xtime4(m4);
            s[c] = (m8 ^ m4 ^ m2) ^ rol32(m8 ^ m2 ^ w, 8) ^ rol32(m8 ^ m4 ^ w, 16)
                   ^ rol32(m8 ^ w, 24);
         end
      end
   endfunction

   function automatic logic [127:0] run_cipher(input logic [127:0] blk, input bit inv);
      logic [31:0] s [4];
      int          r;
      for (int c = 0; c < 4; c++) s[c] = blk[127 - 32*c -: 32];
      if (!inv) begin
         add_round_key(s, 0);
         for (r = 1; r <= n_rounds; r++) begin
            sub_rows(s, 1'b0);
            if (r < n_rounds) mix_cols(s, 1'b0);
            add_round_key(s, 4 * r);
         end
      end else begin
         r = n_rounds;
         add_round_key(s, 4 * r);
         while (r > 0) begin
            r--;
            sub_rows(s, 1'b1);
            add_round_key(s, 4 * r);
            if (r > 0) mix_cols(s, 1'b1);
         end
      end
      return {s[0], s[1], s[2], s[3]};
   endfunction

   // expected output of one accepted request; advances the chaining value
   function automatic blk_out_t predict_block(input blk_req_t rq);
      logic [127:0] prev, din, dout;
      blk_out_t     o;
      prev = rq.chain_start ? {iv_hi_cfg, iv_lo_cfg} : {chain_hi, chain_lo};
      din  = {rq.blk_high, rq.blk_low};
      if (rq.cmd == CMD_CBC_ENC) din ^= prev;
      dout = run_cipher(din, (rq.cmd == CMD_RAW_DEC) || (rq.cmd == CMD_CBC_DEC));
      if (rq.cmd == CMD_CBC_ENC) begin
         {chain_hi, chain_lo} = dout;
      end else if (rq.cmd == CMD_CBC_DEC) begin
         dout ^= prev;
         chain_hi = rq.blk_high;
         chain_lo = rq.blk_low;
      end
      o.high = dout[127:64];
      o.low  = dout[63:0];
      return o;
   endfunction

   // ------------------------------------------------------------------------
   // Bench state
   // ------------------------------------------------------------------------
   blk_req_t pending_reqs [$];
   blk_out_t expected_blocks [$];
   int       err_count = 0;
   bit       no_idle = 1'b0;
   int       hold_ticket = 0;   // bumped to ask the receiver for a long hold-off
   int       cycle_count = 0;
   localparam int CYCLE_LIMIT = 400000;

   // timeout guard
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Request driver: predicts on acceptance, then offers the next request
   // ------------------------------------------------------------------------
   int gap_left = 0;
   always @(posedge clock) begin
      blk_req_t rq;
      bit       take;
      if (!reset) begin
         take = !req_valid;
         if (req_valid && req_ready) begin
            rq.cmd         = cmd_type'(req_command);
            rq.chain_start = req_chain_start;
            rq.blk_high    = req_block_high;
            rq.blk_low     = req_block_low;
            expected_blocks.push_back(predict_block(rq));
            take = 1'b1;
         end
         // valid may only drop once the current request has gone
         if (take) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pending_reqs.size() > 0 &&
                         (no_idle || $urandom_range(0, 5) != 0)) begin
               rq = pending_reqs.pop_front();
               req_valid       <= 1'b1;
               req_command     <= rq.cmd;
               req_chain_start <= rq.chain_start;
               req_block_high  <= rq.blk_high;
               req_block_low   <= rq.blk_low;
            end else begin
               if (!no_idle && pending_reqs.size() > 0) gap_left = $urandom_range(0, 3);
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Result monitor: compares against the oldest prediction, drives ready
   // ------------------------------------------------------------------------
   int stall_left = 0;
   int hold_left = 0;
   int hold_served = 0;
   always @(posedge clock) begin
      blk_out_t ex;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_blocks.size() == 0) begin
               $error("result with nothing expected: %h %h", rsp_result_high, rsp_result_low);
               err_count++;
            end else begin
               ex = expected_blocks.pop_front();
               if (rsp_result_high !== ex.high) begin
                  $error("result_high expected %h actual %h", ex.high, rsp_result_high);
                  err_count++;
               end
               if (rsp_result_low !== ex.low) begin
                  $error("result_low expected %h actual %h", ex.low, rsp_result_low);
                  err_count++;
               end
            end
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (hold_served != hold_ticket) begin
            hold_served = hold_ticket;
            hold_left = 300;
            rsp_ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else if (!no_idle && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 3);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Register writes: setup then access; model updates at the access edge
   // ------------------------------------------------------------------------
   task automatic csr_write(input logic [2:0] idx, input logic [63:0] val);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 3'b000};
      csr_pwdata  <= val;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (idx)
         REG_KEY0:  key_word[0] = val;
         REG_KEY1:  key_word[1] = val;
         REG_KEY2:  key_word[2] = val;
         REG_NK:    key_len_cfg = val[2:0];
         REG_TWEAK: tweak_cfg = val[0];
         REG_IVH:   iv_hi_cfg = val;
         REG_IVL:   iv_lo_cfg = val;
         default:   return;   // unmapped address: no re-expansion
      endcase
      build_schedule();
   endtask

   task automatic write_all(input logic [63:0] k0, input logic [63:0] k1,
                            input logic [63:0] k2, input logic [2:0] nk,
                            input logic tw, input logic [63:0] ivh,
                            input logic [63:0] ivl);
      csr_write(REG_KEY0, k0);
      csr_write(REG_KEY1, k1);
      csr_write(REG_KEY2, k2);
      csr_write(REG_NK, {61'h0, nk});
      csr_write(REG_TWEAK, {63'h0, tw});
      csr_write(REG_IVH, ivh);
      csr_write(REG_IVL, ivl);
   endtask

   // block until every queued request has gone and every result is back
   task automatic wait_drained();
      @(negedge clock);
      while (pending_reqs.size() != 0 || req_valid || expected_blocks.size() != 0)
         @(negedge clock);
   endtask

   function automatic logic [63:0] rnd64();
      return {$urandom, $urandom};
   endfunction

   function automatic logic [63:0] pick64();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return '1;
         default: return rnd64();
      endcase
   endfunction

   task automatic push_req(input cmd_type c, input logic cs, input logic [63:0] h,
                           input logic [63:0] l);
      blk_req_t rq;
      rq.cmd = c;
      rq.chain_start = cs;
      rq.blk_high = h;
      rq.blk_low = l;
      pending_reqs.push_back(rq);
   endtask

   // mostly CBC chains of random length, with raw requests and odd restarts
   task automatic queue_random(input int n);
      int      cnt;
      int      len;
      cmd_type c;
      cnt = 0;
      while (cnt < n) begin
         if ($urandom_range(0, 9) < 7) begin
            c = $urandom_range(0, 1) ? CMD_CBC_ENC : CMD_CBC_DEC;
            len = $urandom_range(2, 8);
            for (int i = 0; i < len; i++) begin
               push_req(c, (i == 0) ? ($urandom_range(0, 5) != 0)
                                    : ($urandom_range(0, 9) == 0),
                        pick64(), pick64());
            end
            cnt += len;
         end else begin
            c = $urandom_range(0, 1) ? CMD_RAW_ENC : CMD_RAW_DEC;
            push_req(c, $urandom_range(0, 1), pick64(), pick64());
            cnt++;
         end
      end
   endtask

   // ------------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------------
   initial begin
      logic [2:0] nk_pick [7];
      nk_pick = '{3'd0, 3'd3, 3'd4, 3'd5, 3'd6, 3'd7, 3'd4};
      key_word = '{64'h0, 64'h0, 64'h0};
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed: all-zero key, shortest schedule, every command and extremes
      write_all('0, '0, '0, 3'd4, 1'b0, '0, '0);
      push_req(CMD_RAW_ENC, 1'b0, '0, '0);
      push_req(CMD_RAW_ENC, 1'b1, '1, '1);
      push_req(CMD_RAW_DEC, 1'b0, '0, '0);
      push_req(CMD_RAW_DEC, 1'b1, '1, '1);
      push_req(CMD_CBC_ENC, 1'b0, '1, '0);   // chain still zero from reset
      push_req(CMD_CBC_ENC, 1'b0, '0, '1);
      push_req(CMD_RAW_ENC, 1'b0, rnd64(), rnd64());   // raw leaves chain alone
      push_req(CMD_CBC_ENC, 1'b0, rnd64(), rnd64());
      push_req(CMD_CBC_DEC, 1'b1, '1, '1);
      push_req(CMD_CBC_DEC, 1'b0, rnd64(), rnd64());
      push_req(CMD_CBC_DEC, 1'b0, '0, '0);
      wait_drained();

      // directed: longest key with tweak, all-ones material
      write_all('1, '1, '1, 3'd6, 1'b1, '1, '1);
      push_req(CMD_CBC_ENC, 1'b1, '0, '0);
      push_req(CMD_CBC_ENC, 1'b0, '1, '1);
      push_req(CMD_RAW_DEC, 1'b1, '0, '1);
      push_req(CMD_CBC_DEC, 1'b1, rnd64(), rnd64());
      push_req(CMD_CBC_DEC, 1'b0, rnd64(), rnd64());
      wait_drained();

      // chaining value survives a key rewrite
      csr_write(REG_KEY0, rnd64());
      push_req(CMD_CBC_DEC, 1'b0, rnd64(), rnd64());
      push_req(CMD_CBC_ENC, 1'b0, rnd64(), rnd64());
      wait_drained();

      // random phases, each on its own setting
      for (int p = 0; p < 8; p++) begin
         write_all(rnd64(), rnd64(), rnd64(), (p < 7) ? nk_pick[p] : 3'($urandom_range(0, 7)),
                   $urandom_range(0, 1), rnd64(), rnd64());
         if (p == 3) csr_write(3'd7, rnd64());   // unmapped register address
         if (p == 7) no_idle = 1'b1;
         queue_random(115);
         if (p == 4) begin
            // long receiver hold-off while the sender keeps offering
            @(negedge clock);
            hold_ticket++;
         end
         wait_drained();
      end

      repeat (40) @(posedge clock);
      if (err_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
